/* rtl/core/tcw_pkg.sv */
// Shared types and constants of the text console writer.
package tcw_pkg;

  // Default geometry of the cell store
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Fixed field widths of the channels
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int ATTR_W  = 8;
  localparam int INDEX_W = 11;
  localparam int CELL_W  = CHAR_W + ATTR_W;

  // Item kinds and special characters
  localparam logic        KIND_PUT     = 1'b0;
  localparam logic        KIND_READ    = 1'b1;
  localparam logic [7:0]  NEWLINE_CODE = 8'h0a;

  // Classified item as held in the queue between front and back
  typedef struct packed {
    logic                 is_read;
    logic                 is_newline;
    logic [CHAR_W-1:0]    char_code;
    logic [ATTR_W-1:0]    attr;
    logic                 eos;
    logic [INDEX_W-1:0]   read_index;
  } tcw_item_t;

  // Queue head as seen by the back part
  typedef struct packed {
    logic      valid;
    tcw_item_t item;
  } tcw_q_t;

  // Control from the back part to the front part
  typedef struct packed {
    logic pop;
    logic clearing;
  } tcw_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_SCROLL_COPY,
    ST_SCROLL_CLR
  } tcw_state_t;

endpackage

/* rtl/core/tcw_if.sv */
// Valid/ready channel interfaces for console items and results.
interface tcw_in_if;
  import tcw_pkg::*;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [CHAR_W-1:0]   char_code;
  logic [COLOR_W-1:0]  fg_color;
  logic [COLOR_W-1:0]  bg_color;
  logic                end_of_string;
  logic [INDEX_W-1:0]  read_index;

  modport source (output valid, kind, char_code, fg_color, bg_color, end_of_string,
                  read_index, input ready);
  modport sink   (input valid, kind, char_code, fg_color, bg_color, end_of_string,
                  read_index, output ready);
endinterface

interface tcw_out_if;
  import tcw_pkg::*;
  logic                valid;
  logic                ready;
  logic [INDEX_W-1:0]  cursor_index;
  logic [INDEX_W-1:0]  cursor_register;
  logic [CHAR_W-1:0]   cell_char;
  logic [ATTR_W-1:0]   cell_attr;
  logic                scrolled;

  modport source (output valid, cursor_index, cursor_register, cell_char, cell_attr,
                  scrolled, input ready);
  modport sink   (input valid, cursor_index, cursor_register, cell_char, cell_attr,
                  scrolled, output ready);
endinterface

/* rtl/core/text_console_writer_core.sv */
// Text console writer: COLUMNS x ROWS cell store with cursor, scroll and read-back.
// A put goes from the queue into the result register; a read also passes the registered store read.
// Throughput: one put per cycle while the result side is ready; a read holds the back part in ST_RD_WAIT.
// A scroll holds the back part through the row copy, then the bottom-row blank.
// Reset: synchronous; the store is then swept to zero with the input held not ready.
// Cursor and cursor register reset to zero.
module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tcw_in_if.sink    in_ch,
  tcw_out_if.source out_ch
);
  import tcw_pkg::*;

  tcw_q_t   q;
  tcw_ctl_t ctl;

  tcw_front u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .ctl  (ctl),
    .q    (q)
  );

  tcw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .q     (q),
    .ctl   (ctl),
    .out_ch(out_ch)
  );

  // No input transfer while the store is being cleared
  a_clear_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clearing |-> !in_ch.ready)
    else $error("input accepted during clearing pass");

  // No queue pop while the store is being cleared
  a_clear_blocks_pop: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clearing |-> !ctl.pop)
    else $error("queue popped during clearing pass");

  // A scrolled result leaves the cursor at the start of the last row with no cell data
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.scrolled) |->
      (out_ch.cursor_index == INDEX_W'((ROWS - 1) * COLUMNS)) &&
      (out_ch.cell_char == '0) && (out_ch.cell_attr == '0))
    else $error("scroll result with wrong cursor or cell data");
endmodule

/* rtl/core/tcw_ram.sv */
// Generic simple dual-port RAM with registered read.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

/* rtl/core/tcw_front.sv */
// Front part: accept and classify items into a two-entry queue.
module tcw_front (
  input  logic              clk,
  input  logic              rst_n,
  tcw_in_if.sink            in_ch,
  input  tcw_pkg::tcw_ctl_t ctl,
  output tcw_pkg::tcw_q_t   q
);
  import tcw_pkg::*;

  localparam int QDEPTH = 2;

  tcw_item_t item_r [QDEPTH];
  logic      wp_r, wp_nxt;
  logic      rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic      push;
  tcw_item_t cls;

  // Accept while there is room and the store is not being cleared
  assign in_ch.ready = (cnt_r != 2'(QDEPTH)) && !ctl.clearing;
  assign push        = in_ch.valid && in_ch.ready;

  // Classify the incoming item
  always_comb begin
    cls.is_read    = (in_ch.kind == KIND_READ);
    cls.is_newline = (in_ch.kind == KIND_PUT) && (in_ch.char_code == NEWLINE_CODE);
    cls.char_code  = in_ch.char_code;
    cls.attr       = {in_ch.bg_color, in_ch.fg_color};
    cls.eos        = in_ch.end_of_string;
    cls.read_index = in_ch.read_index;
  end

  // Advance pointers and count
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = ctl.pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(ctl.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the classified item
  always_ff @(posedge clk) begin
    if (push) begin
      item_r[wp_r] <= cls;
    end
  end

  assign q.valid = (cnt_r != 2'd0);
  assign q.item  = item_r[rp_r];
endmodule

/* rtl/core/tcw_back.sv */
// Back part: carry out puts, reads, scrolls and the clearing pass.
module tcw_back #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tcw_pkg::tcw_q_t   q,
  output tcw_pkg::tcw_ctl_t ctl,
  tcw_out_if.source         out_ch
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  tcw_state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] dst_r, dst_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] creg_r, creg_nxt;

  logic               ov_r, ov_nxt;
  logic [INDEX_W-1:0] o_cidx_r, o_cidx_nxt;
  logic [INDEX_W-1:0] o_creg_r, o_creg_nxt;
  logic [CHAR_W-1:0]  o_char_r, o_char_nxt;
  logic [ATTR_W-1:0]  o_attr_r, o_attr_nxt;
  logic               o_scr_r, o_scr_nxt;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [CELL_W-1:0] wdata, rdata;

  logic slot_free, pop;
  logic col_last, row_last, adv_row, need_scroll;
  logic clr_last, copy_last;

  tcw_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Handshake and cursor decisions
  assign slot_free   = !ov_r || out_ch.ready;
  assign pop         = (state_r == ST_IDLE) && q.valid && slot_free;
  assign col_last    = (col_r == CW'(COLUMNS - 1));
  assign row_last    = (row_r == RW'(ROWS - 1));
  assign adv_row     = q.item.is_newline || col_last;
  assign need_scroll = adv_row && row_last;
  assign clr_last    = (cnt_r == AW'(CELLS - 1));
  assign copy_last   = (cnt_r == AW'(CELLS - COLUMNS - 1));

  assign ctl.pop      = pop;
  assign ctl.clearing = (state_r == ST_CLEAR);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (pop) begin
          if (q.item.is_read) begin
            state_nxt = ST_RD_WAIT;
          end else if (need_scroll) begin
            state_nxt = ST_SCROLL_COPY;
          end
        end
      end
      ST_RD_WAIT: state_nxt = ST_IDLE;
      ST_SCROLL_COPY: begin
        if (copy_last) state_nxt = ST_SCROLL_CLR;
      end
      ST_SCROLL_CLR: begin
        if (!pend_r && clr_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Datapath, store access and result register
  always_comb begin
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    dst_nxt    = dst_r;
    rd_ok_nxt  = rd_ok_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    pos_nxt    = pos_r;
    creg_nxt   = creg_r;
    ov_nxt     = ov_r && !out_ch.ready;
    o_cidx_nxt = o_cidx_r;
    o_creg_nxt = o_creg_r;
    o_char_nxt = o_char_r;
    o_attr_nxt = o_attr_r;
    o_scr_nxt  = o_scr_r;
    we         = 1'b0;
    waddr      = cnt_r;
    wdata      = '0;
    re         = 1'b0;
    raddr      = cnt_r;

    case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        cnt_nxt = clr_last ? '0 : cnt_r + AW'(1);
      end
      ST_IDLE: begin
        if (pop) begin
          if (q.item.is_read) begin
            // Look up the cell; out-of-range reads return zero
            re         = 1'b1;
            raddr      = AW'(q.item.read_index);
            rd_ok_nxt  = (32'(q.item.read_index) < 32'(CELLS));
            o_cidx_nxt = INDEX_W'(pos_r);
            o_creg_nxt = INDEX_W'(creg_r);
            o_scr_nxt  = 1'b0;
          end else begin
            // Write the character unless it is a newline, then move the cursor
            if (!q.item.is_newline) begin
              we    = 1'b1;
              waddr = pos_r;
              wdata = {q.item.attr, q.item.char_code};
            end
            if (need_scroll) begin
              col_nxt = '0;
              row_nxt = RW'(ROWS - 1);
              pos_nxt = AW'(CELLS - COLUMNS);
              cnt_nxt = '0;
            end else if (q.item.is_newline) begin
              col_nxt = '0;
              row_nxt = row_r + RW'(1);
              pos_nxt = pos_r - AW'(col_r) + AW'(COLUMNS);
            end else begin
              col_nxt = col_last ? '0 : col_r + CW'(1);
              row_nxt = col_last ? row_r + RW'(1) : row_r;
              pos_nxt = pos_r + AW'(1);
            end
            if (q.item.eos) creg_nxt = pos_nxt;
            o_cidx_nxt = INDEX_W'(pos_nxt);
            o_creg_nxt = INDEX_W'(creg_nxt);
            o_char_nxt = '0;
            o_attr_nxt = '0;
            o_scr_nxt  = need_scroll;
            ov_nxt     = !need_scroll;
          end
        end
      end
      ST_RD_WAIT: begin
        o_char_nxt = rd_ok_r ? rdata[CHAR_W-1:0] : '0;
        o_attr_nxt = rd_ok_r ? rdata[CELL_W-1:CHAR_W] : '0;
        ov_nxt     = 1'b1;
      end
      ST_SCROLL_COPY: begin
        // Read one row ahead, write the cell fetched last cycle
        re       = 1'b1;
        raddr    = cnt_r + AW'(COLUMNS);
        pend_nxt = 1'b1;
        dst_nxt  = cnt_r;
        if (pend_r) begin
          we    = 1'b1;
          waddr = dst_r;
          wdata = rdata;
        end
        cnt_nxt = cnt_r + AW'(1);
      end
      ST_SCROLL_CLR: begin
        // Finish the last copy, then blank the bottom row
        pend_nxt = 1'b0;
        we       = 1'b1;
        if (pend_r) begin
          waddr = dst_r;
          wdata = rdata;
        end else begin
          cnt_nxt = clr_last ? '0 : cnt_r + AW'(1);
          if (clr_last) ov_nxt = 1'b1;
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      col_r   <= '0;
      row_r   <= '0;
      pos_r   <= '0;
      creg_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      pos_r   <= pos_nxt;
      creg_r  <= creg_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    dst_r    <= dst_nxt;
    rd_ok_r  <= rd_ok_nxt;
    o_cidx_r <= o_cidx_nxt;
    o_creg_r <= o_creg_nxt;
    o_char_r <= o_char_nxt;
    o_attr_r <= o_attr_nxt;
    o_scr_r  <= o_scr_nxt;
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.cursor_index    = o_cidx_r;
  assign out_ch.cursor_register = o_creg_r;
  assign out_ch.cell_char       = o_char_r;
  assign out_ch.cell_attr       = o_attr_r;
  assign out_ch.scrolled        = o_scr_r;
endmodule

/* sim/console_checker.sv */
// Result checker for the text console writer: tracks the cell store and compares every result.
`timescale 1ns / 100ps

module console_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  tcw_in_if    in_ch,
  tcw_out_if   out_ch,
  output int   fail_count,
  output int   pending_count,
  output int   scroll_count
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [INDEX_W-1:0] cursor_index;
    logic [INDEX_W-1:0] cursor_register;
    logic [CHAR_W-1:0]  cell_char;
    logic [ATTR_W-1:0]  cell_attr;
    logic               scrolled;
  } console_result_t;

  // Shadow of the console state
  logic [CELL_W-1:0] screen [CELLS];
  int                cur_col;
  int                cur_row;
  int                cursor_reg;
  console_result_t   console_results_q [$];
  console_result_t   want;
  console_result_t   seen;

  // Apply one accepted item to the shadow state and return the result it should produce
  function automatic console_result_t apply_item(input logic kind, input logic [7:0] ch,
                                                 input logic [3:0] fg, input logic [3:0] bg,
                                                 input logic eos, input logic [10:0] idx);
    console_result_t res;
    int              pos;
    res = '0;
    if (kind == KIND_READ) begin
      // Out-of-range reads return an empty cell
      if (int'(idx) < CELLS) begin
        res.cell_char = screen[idx][CHAR_W-1:0];
        res.cell_attr = screen[idx][CELL_W-1:CHAR_W];
      end
    end else begin
      if (ch == NEWLINE_CODE) begin
        cur_row++;
        cur_col = 0;
      end else begin
        pos = cur_row * COLUMNS + cur_col;
        if (pos < CELLS) screen[pos] = {bg, fg, ch};
        cur_col++;
      end
      // Wrap past the last column
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_row++;
      end
      // Scroll up one row, blank the bottom row
      if (cur_row >= ROWS) begin
        cur_row = ROWS - 1;
        cur_col = 0;
        for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = '0;
        res.scrolled = 1'b1;
        scroll_count++;
      end
      if (eos) cursor_reg = cur_row * COLUMNS + cur_col;
    end
    res.cursor_index    = INDEX_W'(cur_row * COLUMNS + cur_col);
    res.cursor_register = INDEX_W'(cursor_reg);
    return res;
  endfunction

  // Compare result transfers first, then record what each input transfer should produce
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) screen[i] = '0;
      cur_col = 0;
      cur_row = 0;
      cursor_reg = 0;
      console_results_q.delete();
      fail_count = 0;
      scroll_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen = '{out_ch.cursor_index, out_ch.cursor_register, out_ch.cell_char,
                 out_ch.cell_attr, out_ch.scrolled};
        if (console_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with nothing outstanding: cursor %0d reg %0d char %02h",
                     $time, seen.cursor_index, seen.cursor_register, seen.cell_char);
        end else begin
          want = console_results_q.pop_front();
          if (seen !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: mismatch cursor exp %0d got %0d, reg exp %0d got %0d, ",
                        "char exp %02h got %02h, attr exp %02h got %02h, ",
                        "scrolled exp %0b got %0b"},
                       $time, want.cursor_index, seen.cursor_index,
                       want.cursor_register, seen.cursor_register,
                       want.cell_char, seen.cell_char, want.cell_attr, seen.cell_attr,
                       want.scrolled, seen.scrolled);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        console_results_q.push_back(apply_item(in_ch.kind, in_ch.char_code, in_ch.fg_color,
                                               in_ch.bg_color, in_ch.end_of_string,
                                               in_ch.read_index));
    end
    pending_count = console_results_q.size();
  end

endmodule

/* sim/testbench.sv */
// Top of the text console writer testbench: clock, reset, stimulus, result stalls and verdict.
`timescale 1ns / 100ps

module testbench;
  import tcw_pkg::*;

  localparam int COLUMNS     = COLUMNS_DEF;
  localparam int ROWS        = ROWS_DEF;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int ITEM_TARGET = 1650;
  localparam int PAUSE_EVERY = 350;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();

  int fail_count;
  int pending_count;
  int scroll_count;
  int sent_puts;
  int sent_newlines;
  int sent_reads;
  int since_pause;
  bit quiet_in;
  bit quiet_out;

  text_console_writer_core #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  console_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .scroll_count  (scroll_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_printable();
    logic [7:0] ch;
    do ch = 8'($urandom); while (ch == NEWLINE_CODE);
    return ch;
  endfunction

  // Bias reads toward the bottom rows, where fresh text lands once the screen fills
  function automatic logic [10:0] pick_read_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 11'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
    if (r < 80) return 11'($urandom_range(0, CELLS - 1));
    if (r < 90) return 11'($urandom_range(CELLS, 2047));
    if (r < 95) return 11'(CELLS - 1);
    return 11'(0);
  endfunction

  // Present one item at the falling edge, hold it until the transfer, then maybe idle a while
  task automatic send_item(input logic kind, input logic [7:0] ch, input logic [3:0] fg,
                           input logic [3:0] bg, input logic eos, input logic [10:0] idx);
    int gap;
    @(negedge clk);
    in_ch.kind          = kind;
    in_ch.char_code     = ch;
    in_ch.fg_color      = fg;
    in_ch.bg_color      = bg;
    in_ch.end_of_string = eos;
    in_ch.read_index    = idx;
    in_ch.valid         = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (kind == KIND_READ) sent_reads++;
    else if (ch == NEWLINE_CODE) sent_newlines++;
    else sent_puts++;
    since_pause++;
    gap = quiet_in ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic put_char(input logic [7:0] ch, input logic [3:0] fg, input logic [3:0] bg,
                          input logic eos);
    send_item(KIND_PUT, ch, fg, bg, eos, 11'($urandom));
  endtask

  task automatic read_cell(input logic [10:0] idx, input logic eos);
    send_item(KIND_READ, 8'($urandom), 4'($urandom), 4'($urandom), eos, idx);
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (pending_count == 0);
    since_pause = 0;
  endtask

  // Result-side stalls, with calm stretches in between
  initial begin
    int stall;
    int phase_left;
    stall      = 0;
    phase_left = 0;
    quiet_out  = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        quiet_out  = ($urandom_range(0, 3) == 0);
        phase_left = $urandom_range(50, 400);
      end
      phase_left--;
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else if (!quiet_out && $urandom_range(0, 99) < 25) begin
        out_ch.ready = 1'b0;
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int         r;
    int         len;
    logic [3:0] fg;
    logic [3:0] bg;
    logic       nl_end;
    in_ch.valid         = 1'b0;
    in_ch.kind          = KIND_PUT;
    in_ch.char_code     = '0;
    in_ch.fg_color      = '0;
    in_ch.bg_color      = '0;
    in_ch.end_of_string = 1'b0;
    in_ch.read_index    = '0;
    quiet_in      = 1'b0;
    sent_puts     = 0;
    sent_newlines = 0;
    sent_reads    = 0;
    since_pause   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty store, field extremes, range edges, end of string on a read, newlines
    read_cell(11'd0, 1'b1);
    put_char(8'h00, 4'h0, 4'h0, 1'b0);
    put_char(8'hff, 4'hf, 4'hf, 1'b1);
    put_char(8'h41, 4'ha, 4'h5, 1'b0);
    read_cell(11'd0, 1'b0);
    read_cell(11'd1, 1'b0);
    read_cell(11'd2, 1'b1);
    read_cell(11'(CELLS - 1), 1'b0);
    read_cell(11'(CELLS), 1'b0);
    read_cell(11'd2047, 1'b1);
    send_item(KIND_PUT, NEWLINE_CODE, 4'h3, 4'hc, 1'b1, 11'd2047);
    send_item(KIND_PUT, NEWLINE_CODE, 4'h0, 4'h0, 1'b0, 11'd0);
    put_char(8'h7f, 4'h5, 4'ha, 1'b1);
    read_cell(11'(2 * COLUMNS), 1'b0);
    read_cell(11'(COLUMNS), 1'b0);
    drain_results();

    // Random: strings ending in end of string, long lines that wrap, read bursts, noise
    while (sent_puts + sent_newlines + sent_reads < ITEM_TARGET) begin
      quiet_in = ($urandom_range(0, 4) == 0);
      fg = 4'($urandom);
      bg = 4'($urandom);
      r  = $urandom_range(0, 99);
      if (r < 45) begin
        len    = $urandom_range(1, 12);
        nl_end = ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++) begin
          if (i == len - 1)
            put_char(nl_end ? NEWLINE_CODE : pick_printable(), fg, bg, 1'b1);
          else
            put_char(pick_printable(), fg, bg, $urandom_range(0, 19) == 0);
        end
      end else if (r < 62) begin
        len = $urandom_range(60, 100);
        for (int i = 0; i < len; i++)
          put_char(pick_printable(), fg, bg, i == len - 1);
      end else if (r < 90) begin
        len = $urandom_range(1, 6);
        repeat (len) read_cell(pick_read_index(), $urandom_range(0, 9) == 0);
      end else begin
        send_item(1'($urandom), 8'($urandom), 4'($urandom), 4'($urandom), 1'($urandom),
                  11'($urandom));
      end
      if (since_pause > PAUSE_EVERY) drain_results();
    end

    // Let the last results come back, then a short drain
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (pending_count == 0);
    repeat (20) @(posedge clk);
    $display("Covered %0d characters, %0d newlines and %0d cell reads on an %0dx%0d store;",
             sent_puts, sent_newlines, sent_reads, COLUMNS, ROWS);
    $display("%0d scrolls expected, %0d failures.", scroll_count, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, sized for every item forcing a full scroll under the longest stalls
  initial begin
    #200ms;
    $display("FAIL");
    $finish;
  end

endmodule
